[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the string unescape unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge out of reset.
`define JSU_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// Condition must never be seen on a clock edge out of reset.
`define JSU_NEVER(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);

`endif

[rtl/core/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and codes shared by the string unescape unit.
// ----------------------------------------------------------------------------
package jsu_pkg;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_BAD_ESC    = 3'd1,
        ERR_BAD_HEX    = 3'd2,
        ERR_NO_LOW     = 3'd3,
        ERR_LOW_RANGE  = 3'd4,
        ERR_UNTERM     = 3'd5
    } err_t;

    localparam int MAX_WORDS = 4;

    typedef struct packed {
        logic       last;
        err_t       error_code;
        logic [7:0] data_byte;
        kind_t      kind;
    } result_t;

    // Up to four output words produced by one input byte.
    typedef struct packed {
        logic [2:0]                  cnt;
        result_t [MAX_WORDS-1:0]     word;
    } grp_t;

endpackage

[rtl/core/jsu_decode.sv]
// ----------------------------------------------------------------------------
// jsu_decode
// Escape parser state and combinational decode of one byte into a word group.
// ----------------------------------------------------------------------------
module jsu_decode
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic              text_ends,
    output jsu_pkg::grp_t     grp
);

    typedef enum logic [3:0] {
        PH_PLAIN   = 4'd0,
        PH_ESC     = 4'd1,
        PH_HEX_HI  = 4'd2,
        PH_WANT_BS = 4'd3,
        PH_WANT_U  = 4'd4,
        PH_HEX_LO  = 4'd5
    } phase_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    phase_t      phase_reg, phase_next;
    logic [15:0] acc_reg, acc_next;
    logic [9:0]  hi_reg, hi_next;
    logic [1:0]  cnt_reg, cnt_next;

    jsu_pkg::err_t err;
    logic          closed;
    logic          hex_ok;
    logic [3:0]    hex_val;
    logic [15:0]   acc_new;
    logic [20:0]   pair_code;

    function automatic jsu_pkg::result_t data_word(input logic [7:0] b, input logic lst);
        jsu_pkg::result_t r;
        r.kind       = jsu_pkg::KIND_DATA;
        r.data_byte  = b;
        r.error_code = jsu_pkg::ERR_NONE;
        r.last       = lst;
        return r;
    endfunction

    function automatic jsu_pkg::grp_t encode_utf8(input logic [20:0] code);
        jsu_pkg::grp_t g;
        g = '0;
        if (code < 21'h80)
        begin
            g.cnt     = 3'd1;
            g.word[0] = data_word(code[7:0], 1'b1);
        end
        else if (code < 21'h800)
        begin
            g.cnt     = 3'd2;
            g.word[0] = data_word({3'b110, code[10:6]}, 1'b0);
            g.word[1] = data_word({2'b10, code[5:0]}, 1'b1);
        end
        else if (code < 21'h10000)
        begin
            g.cnt     = 3'd3;
            g.word[0] = data_word({4'b1110, code[15:12]}, 1'b0);
            g.word[1] = data_word({2'b10, code[11:6]}, 1'b0);
            g.word[2] = data_word({2'b10, code[5:0]}, 1'b1);
        end
        else
        begin
            g.cnt     = 3'd4;
            g.word[0] = data_word({5'b11110, code[20:18]}, 1'b0);
            g.word[1] = data_word({2'b10, code[17:12]}, 1'b0);
            g.word[2] = data_word({2'b10, code[11:6]}, 1'b0);
            g.word[3] = data_word({2'b10, code[5:0]}, 1'b1);
        end
        return g;
    endfunction

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
            hex_val = in_byte[3:0];
        else if ((in_byte >= 8'h61 && in_byte <= 8'h66) || (in_byte >= 8'h41 && in_byte <= 8'h46))
            hex_val = in_byte[3:0] + 4'd9;
        else
            hex_ok = 1'b0;
    end

    assign acc_new   = {acc_reg[11:0], hex_val};
    // low unit is DC00..DFFF, so its low ten bits are the offset
    assign pair_code = {1'b0, hi_reg, acc_new[9:0]} + 21'h10000;

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        hi_next    = hi_reg;
        cnt_next   = cnt_reg;
        err        = jsu_pkg::ERR_NONE;
        closed     = 1'b0;
        grp        = '0;

        unique case (phase_reg)
            PH_ESC:
            begin
                phase_next = PH_PLAIN;
                priority if (in_byte == CH_BSL || in_byte == CH_QUOTE)
                begin
                    grp.cnt = 3'd1; grp.word[0] = data_word(in_byte, 1'b1);
                end
                else if (in_byte == CH_N)
                begin
                    grp.cnt = 3'd1; grp.word[0] = data_word(8'h0A, 1'b1);
                end
                else if (in_byte == CH_R)
                begin
                    grp.cnt = 3'd1; grp.word[0] = data_word(8'h0D, 1'b1);
                end
                else if (in_byte == CH_T)
                begin
                    grp.cnt = 3'd1; grp.word[0] = data_word(8'h09, 1'b1);
                end
                else if (in_byte == CH_U)
                begin
                    phase_next = PH_HEX_HI;
                    acc_next   = '0;
                    cnt_next   = '0;
                end
                else
                    err = jsu_pkg::ERR_BAD_ESC;
            end
            PH_HEX_HI, PH_HEX_LO:
            begin
                if (!hex_ok)
                    err = jsu_pkg::ERR_BAD_HEX;
                else if (cnt_reg != 2'd3)
                begin
                    acc_next = acc_new;
                    cnt_next = cnt_reg + 2'd1;
                end
                else
                begin
                    cnt_next = '0;
                    acc_next = '0;
                    if (phase_reg == PH_HEX_HI)
                    begin
                        if (acc_new[15:10] == 6'b110110)
                        begin
                            hi_next    = acc_new[9:0];
                            phase_next = PH_WANT_BS;
                        end
                        else
                        begin
                            grp        = encode_utf8({5'd0, acc_new});
                            phase_next = PH_PLAIN;
                        end
                    end
                    else if (acc_new[15:10] != 6'b110111)
                        err = jsu_pkg::ERR_LOW_RANGE;
                    else
                    begin
                        grp        = encode_utf8(pair_code);
                        phase_next = PH_PLAIN;
                        hi_next    = '0;
                    end
                end
            end
            PH_WANT_BS:
            begin
                if (in_byte == CH_BSL)
                    phase_next = PH_WANT_U;
                else
                    err = jsu_pkg::ERR_NO_LOW;
            end
            PH_WANT_U:
            begin
                if (in_byte == CH_U)
                begin
                    phase_next = PH_HEX_LO;
                    acc_next   = '0;
                    cnt_next   = '0;
                end
                else
                    err = jsu_pkg::ERR_NO_LOW;
            end
            default:
            begin
                phase_next = PH_PLAIN;
                priority if (in_byte == CH_QUOTE)
                begin
                    grp.cnt             = 3'd1;
                    grp.word[0].kind    = jsu_pkg::KIND_END;
                    grp.word[0].last    = 1'b1;
                    closed              = 1'b1;
                end
                else if (in_byte == CH_BSL)
                    phase_next = PH_ESC;
                else
                begin
                    grp.cnt = 3'd1; grp.word[0] = data_word(in_byte, 1'b1);
                end
            end
        endcase

        if (err == jsu_pkg::ERR_NONE && !closed && text_ends)
            err = jsu_pkg::ERR_UNTERM;

        if (err != jsu_pkg::ERR_NONE)
        begin
            phase_next                = PH_PLAIN;
            acc_next                  = '0;
            hi_next                   = '0;
            cnt_next                  = '0;
            grp                       = '0;
            grp.cnt                   = 3'd1;
            grp.word[0].kind          = jsu_pkg::KIND_ERROR;
            grp.word[0].error_code    = err;
            grp.word[0].last          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PLAIN;
            acc_reg   <= '0;
            hi_reg    <= '0;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            hi_reg    <= hi_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[rtl/core/jsu_group_buf.sv]
// ----------------------------------------------------------------------------
// jsu_group_buf
// Holds one decoded word group and feeds it word by word to an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_group_buf
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  jsu_pkg::grp_t      grp_in,
    output logic               out_valid,
    input  logic               out_ready,
    output jsu_pkg::result_t   out_word
);

    jsu_pkg::grp_t    grp_reg;
    logic [2:0]       rem_reg, rem_next;
    logic [1:0]       idx_reg, idx_next;
    logic             out_valid_reg;
    jsu_pkg::result_t out_reg;

    logic out_free;
    logic move;
    logic load;

    assign out_free = !out_valid_reg || out_ready;
    assign move     = (rem_reg != 3'd0) && out_free;
    // room for a new group once the last held word moves out
    assign in_ready = (rem_reg == 3'd0) || (rem_reg == 3'd1 && out_free);
    assign load     = in_valid && in_ready;

    always_comb
    begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (load && grp_in.cnt != 3'd0)
        begin
            rem_next = grp_in.cnt;
            idx_next = '0;
        end
        else if (move)
        begin
            rem_next = rem_reg - 3'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
            if (move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && grp_in.cnt != 3'd0)
            grp_reg <= grp_in;
        if (move)
            out_reg <= grp_reg.word[idx_reg];
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    `JSU_NEVER(a_rem_range, clk, rst_n, rem_reg > 3'd4, "word group count out of range")
    `JSU_ASSERT(a_last_word, clk, rst_n, move && rem_reg == 3'd1 |-> grp_reg.word[idx_reg].last, "final word of group lacks last")
    `JSU_ASSERT(a_load_cnt, clk, rst_n, load && grp_in.cnt != 3'd0 |=> rem_reg == $past(grp_in.cnt), "group count not captured")

endmodule

[rtl/core/json_string_unescape_unit.sv]
// ----------------------------------------------------------------------------
// json_string_unescape_unit
// Unescapes a JSON string body byte stream into UTF-8 bytes, end and error words.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                          | tuser     | tlast
//  s_*     | in  | [7:0] in_byte                  | -         | text_ends
//  m_*     | out | [7:0] data_byte, [10:8] error  | [1:0] kind| last of this byte
//
//  One input byte is taken per cycle; its results (one to four words) are
//  decoded in that cycle and leave through a registered output one word a cycle.
//  A byte that yields two or more words holds the input while the
//  group register drains; escape bytes that yield nothing pass at full rate.
//  rst_n clears the parser phase and empties the group and output registers.
//  m_tready low stalls the output register and, once the group is full, s_tready.
// ----------------------------------------------------------------------------
module json_string_unescape_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // text_ends
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [10:8] error_code, [15:11] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    jsu_pkg::grp_t    grp;
    jsu_pkg::result_t word;
    logic             ready;

    jsu_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (s_tvalid && ready),
        .in_byte   (s_tdata),
        .text_ends (s_tlast),
        .grp       (grp)
    );

    jsu_group_buf u_group_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (ready),
        .grp_in    (grp),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (word)
    );

    assign s_tready = ready;
    assign m_tdata  = {5'd0, word.error_code, word.data_byte};
    assign m_tuser  = word.kind;
    assign m_tlast  = word.last;

endmodule
